/* rtl/wfsw_pkg.sv */
package wfsw_pkg;

    localparam int MAX_WIDTH  = 320;
    localparam int MAX_HEIGHT = 240;
    localparam int PIXEL_BITS = 24;

    localparam int FW_W = 9;
    localparam int FH_W = 8;
    localparam int COLOR_W = 24;
    localparam int COORD_W = 16;

    localparam logic [FW_W-1:0] WIDTH_AT_RESET  = 9'd320;
    localparam logic [FH_W-1:0] HEIGHT_AT_RESET = 8'd240;

    localparam int COL_W = (MAX_WIDTH > 512) ? FW_W : $clog2(MAX_WIDTH);
    localparam int ROW_W = (MAX_HEIGHT > 256) ? FH_W : $clog2(MAX_HEIGHT);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int SUM_W = ((ADDR_W > FW_W + ROW_W) ? ADDR_W : FW_W + ROW_W) + 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int PEND_W = $clog2(OUT_DEPTH + 1) + 1;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_PIXEL_MODE   = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_8  = 2'd0,
        MODE_12 = 2'd1,
        MODE_16 = 2'd2,
        MODE_24 = 2'd3
    } pix_mode_t;

    localparam logic [1:0] MODE_AT_RESET = MODE_16;

    typedef enum logic [1:0] {
        OP_SET_WINDOW = 2'd0,
        OP_STREAM     = 2'd1,
        OP_DRAW       = 2'd2,
        OP_READ       = 2'd3
    } op_t;

    typedef struct packed {
        logic [FW_W-1:0]    eff_w;
        logic [FH_W-1:0]    eff_h;
        logic [COLOR_W-1:0] mask;
    } cfg_t;

    typedef struct packed {
        logic                  rd;
        logic                  hit;
        logic [COL_W-1:0]      col;
        logic [ROW_W-1:0]      row;
        logic [PIXEL_BITS-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic                  hit;
        logic [PIXEL_BITS-1:0] value;
    } res_t;

    function automatic logic [FW_W-1:0] eff_width(logic [FW_W-1:0] fw);
        if (int'(fw) > MAX_WIDTH)
            return FW_W'(MAX_WIDTH);
        return fw;
    endfunction

    function automatic logic [FH_W-1:0] eff_height(logic [FH_W-1:0] fh);
        if (int'(fh) > MAX_HEIGHT)
            return FH_W'(MAX_HEIGHT);
        return fh;
    endfunction

    function automatic logic [COLOR_W-1:0] pix_mask(logic [1:0] mode);
        int bits;
        case (pix_mode_t'(mode))
            MODE_8:  bits = 8;
            MODE_12: bits = 12;
            MODE_16: bits = 16;
            default: bits = 24;
        endcase
        if (bits > PIXEL_BITS)
            bits = PIXEL_BITS;
        return COLOR_W'((33'd1 << bits) - 33'd1);
    endfunction

endpackage

/* rtl/wfsw_if.sv */
interface wfsw_in_if;
    import wfsw_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic [COORD_W-1:0]        win_col_lo;
    logic [COORD_W-1:0]        win_col_hi;
    logic [COORD_W-1:0]        win_row_lo;
    logic [COORD_W-1:0]        win_row_hi;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [COLOR_W-1:0]        color;

    modport source (
        output valid, op, win_col_lo, win_col_hi, win_row_lo, win_row_hi,
        output pos_x, pos_y, color,
        input  ready
    );

    modport sink (
        input  valid, op, win_col_lo, win_col_hi, win_row_lo, win_row_hi,
        input  pos_x, pos_y, color,
        output ready
    );
endinterface

interface wfsw_out_if;
    import wfsw_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_value;
    logic               hit;

    modport source (
        output valid, pixel_value, hit,
        input  ready
    );

    modport sink (
        input  valid, pixel_value, hit,
        output ready
    );
endinterface

/* rtl/windowed_frame_store_writer_top.sv */
// Frame memory of a display controller, one word per pixel of a frame of up to
// MAX_WIDTH x MAX_HEIGHT. Requests set the write window, stream a pixel at the window
// cursor, draw a pixel at x,y or read one back; only reads give a response, in request
// order. A request is taken every cycle while the four-entry command queue has room; a
// read leaves the queue only while the four-entry response buffer can hold every read in
// flight, so a stalled response side fills the queue and then holds off requests. A read's
// response passes through the address register, the registered memory read and the
// response buffer before it is offered. After reset the memory is cleared one word a
// cycle, so no request is taken until all MAX_WIDTH*MAX_HEIGHT words (76800 at 320 x
// 240) are cleared; register writes are taken throughout.
module windowed_frame_store_writer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wfsw_pkg::PADDR_W-1:0]  paddr,
    input  logic [wfsw_pkg::PDATA_W-1:0]  pwdata,
    output logic [wfsw_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    wfsw_in_if.sink                       in_ch,
    wfsw_out_if.source                    out_ch
);
    import wfsw_pkg::*;

    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [1:0]      pixel_mode_reg;

    logic            cfg_wr;
    cfg_t            cfg;
    logic            push;
    cmd_t            push_cmd;
    logic            pop;
    logic            q_valid;
    logic            q_full;
    cmd_t            q_cmd;
    logic            clearing;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_AT_RESET;
            frame_height_reg <= HEIGHT_AT_RESET;
            pixel_mode_reg   <= MODE_AT_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
                REG_PIXEL_MODE:   pixel_mode_reg   <= pwdata[1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_reg);
            REG_PIXEL_MODE:   prdata = PDATA_W'(pixel_mode_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.eff_w = eff_width(frame_width_reg);
    assign cfg.eff_h = eff_height(frame_height_reg);
    assign cfg.mask  = pix_mask(pixel_mode_reg);

    wfsw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .cfg      (cfg),
        .q_full   (q_full),
        .clearing (clearing),
        .push     (push),
        .cmd      (push_cmd)
    );

    wfsw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .q_cmd    (q_cmd)
    );

    wfsw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .clearing (clearing),
        .out_ch   (out_ch)
    );

endmodule

/* rtl/wfsw_front.sv */
module wfsw_front (
    input  logic            clk,
    input  logic            rst_n,
    wfsw_in_if.sink         in_ch,
    input  wfsw_pkg::cfg_t  cfg,
    input  logic            q_full,
    input  logic            clearing,
    output logic            push,
    output wfsw_pkg::cmd_t  cmd
);
    import wfsw_pkg::*;

    logic [COORD_W-1:0] cursor_col_reg, cursor_col_next;
    logic [COORD_W-1:0] cursor_row_reg, cursor_row_next;
    logic [COORD_W-1:0] col_lo_reg, col_lo_next;
    logic [COORD_W-1:0] col_hi_reg, col_hi_next;
    logic [COORD_W-1:0] row_lo_reg, row_lo_next;
    logic [COORD_W-1:0] row_hi_reg, row_hi_next;

    logic               accept;
    logic [COORD_W-1:0] s_col;
    logic [COORD_W-1:0] s_row;
    logic               s_in;
    logic               p_in;

    assign in_ch.ready = !q_full && !clearing;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        col_lo_next     = col_lo_reg;
        col_hi_next     = col_hi_reg;
        row_lo_next     = row_lo_reg;
        row_hi_next     = row_hi_reg;

        // cursor wrap before the stream write lands
        s_col = cursor_col_reg;
        s_row = cursor_row_reg;
        if (s_col > col_hi_reg)
        begin
            s_col = col_lo_reg;
            s_row = s_row + 16'd1;
        end
        if (s_row > row_hi_reg)
            s_row = row_lo_reg;
        s_in = (s_col < COORD_W'(cfg.eff_w)) && (s_row < COORD_W'(cfg.eff_h));

        p_in = !in_ch.pos_x[COORD_W-1] && !in_ch.pos_y[COORD_W-1]
            && (in_ch.pos_x[COORD_W-2:0] < (COORD_W-1)'(cfg.eff_w))
            && (in_ch.pos_y[COORD_W-2:0] < (COORD_W-1)'(cfg.eff_h));

        push     = 1'b0;
        cmd.rd   = 1'b0;
        cmd.hit  = p_in;
        cmd.col  = in_ch.pos_x[COL_W-1:0];
        cmd.row  = in_ch.pos_y[ROW_W-1:0];
        cmd.data = PIXEL_BITS'(in_ch.color & cfg.mask);

        if (accept)
        begin
            case (op_t'(in_ch.op))
                OP_SET_WINDOW:
                begin
                    col_lo_next     = in_ch.win_col_lo;
                    col_hi_next     = in_ch.win_col_hi;
                    row_lo_next     = in_ch.win_row_lo;
                    row_hi_next     = in_ch.win_row_hi;
                    cursor_col_next = in_ch.win_col_lo;
                    cursor_row_next = in_ch.win_row_lo;
                end
                OP_STREAM:
                begin
                    push            = s_in;
                    cmd.hit         = s_in;
                    cmd.col         = s_col[COL_W-1:0];
                    cmd.row         = s_row[ROW_W-1:0];
                    cursor_col_next = s_col + 16'd1;
                    cursor_row_next = s_row;
                end
                OP_DRAW:
                begin
                    push = p_in;
                end
                OP_READ:
                begin
                    push   = 1'b1;
                    cmd.rd = 1'b1;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            col_lo_reg     <= '0;
            col_hi_reg     <= COORD_W'(WIDTH_AT_RESET) - 16'd1;
            row_lo_reg     <= '0;
            row_hi_reg     <= COORD_W'(HEIGHT_AT_RESET) - 16'd1;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            col_lo_reg     <= col_lo_next;
            col_hi_reg     <= col_hi_next;
            row_lo_reg     <= row_lo_next;
            row_hi_reg     <= row_hi_next;
        end
    end

endmodule

/* rtl/wfsw_queue.sv */
module wfsw_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wfsw_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           q_valid,
    output logic           q_full,
    output wfsw_pkg::cmd_t q_cmd
);
    import wfsw_pkg::*;

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/wfsw_back.sv */
module wfsw_back (
    input  logic           clk,
    input  logic           rst_n,
    input  wfsw_pkg::cfg_t cfg,
    input  logic           q_valid,
    input  wfsw_pkg::cmd_t q_cmd,
    output logic           pop,
    output logic           clearing,
    wfsw_out_if.source     out_ch
);
    import wfsw_pkg::*;

    logic [PIXEL_BITS-1:0] store [STORE_DEPTH];

    logic                  clearing_reg, clearing_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_rd_reg;
    logic                  s1_hit_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic [PIXEL_BITS-1:0] s1_data_reg;

    logic                  s2_valid_reg, s2_valid_next;
    logic                  s2_hit_reg;
    logic [PIXEL_BITS-1:0] rd_data_reg;

    res_t                  res_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  o_wr_ptr_reg, o_wr_ptr_next;
    logic [OUT_PTR_W-1:0]  o_rd_ptr_reg, o_rd_ptr_next;
    logic [OUT_PTR_W:0]    o_count_reg, o_count_next;

    logic [PEND_W-1:0]     pending;
    logic [ADDR_W-1:0]     cmd_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [PIXEL_BITS-1:0] wr_data;
    logic                  o_push;
    logic                  o_pop;
    res_t                  o_res;
    res_t                  o_head;

    assign clearing = clearing_reg;

    // reads in flight plus results held must fit the result buffer
    assign pending = PEND_W'(s1_valid_reg && s1_rd_reg) + PEND_W'(s2_valid_reg)
                   + PEND_W'(o_count_reg);
    assign pop = q_valid && !clearing_reg
              && (!q_cmd.rd || (pending < PEND_W'(OUT_DEPTH)));

    assign cmd_addr = ADDR_W'(SUM_W'(q_cmd.row) * SUM_W'(cfg.eff_w) + SUM_W'(q_cmd.col));

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                clearing_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + 1'b1;
        end

        if (clearing_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = s1_valid_reg && !s1_rd_reg && s1_hit_reg;
            wr_addr = s1_addr_reg;
            wr_data = s1_data_reg;
        end

        s1_valid_next = pop;
        s2_valid_next = s1_valid_reg && s1_rd_reg;

        o_push      = s2_valid_reg;
        o_res.hit   = s2_hit_reg;
        o_res.value = s2_hit_reg ? rd_data_reg : '0;
        o_pop       = out_ch.valid && out_ch.ready;

        o_wr_ptr_next = o_push ? o_wr_ptr_reg + 1'b1 : o_wr_ptr_reg;
        o_rd_ptr_next = o_pop ? o_rd_ptr_reg + 1'b1 : o_rd_ptr_reg;
        o_count_next  = o_count_reg + (OUT_PTR_W+1)'(o_push) - (OUT_PTR_W+1)'(o_pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[wr_addr] <= wr_data;
        rd_data_reg <= store[s1_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_rd_reg   <= q_cmd.rd;
            s1_hit_reg  <= q_cmd.hit;
            s1_addr_reg <= cmd_addr;
            s1_data_reg <= q_cmd.data;
        end
        s2_hit_reg <= s1_hit_reg;
        if (o_push)
            res_reg[o_wr_ptr_reg] <= o_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o_wr_ptr_reg <= '0;
            o_rd_ptr_reg <= '0;
            o_count_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            o_wr_ptr_reg <= o_wr_ptr_next;
            o_rd_ptr_reg <= o_rd_ptr_next;
            o_count_reg  <= o_count_next;
        end
    end

    assign o_head             = res_reg[o_rd_ptr_reg];
    assign out_ch.valid       = (o_count_reg != '0);
    assign out_ch.pixel_value = COLOR_W'(o_head.value);
    assign out_ch.hit         = o_head.hit;

endmodule

/* tb/windowed_frame_store_writer_top_tb.sv */
`timescale 1ns / 100ps

module windowed_frame_store_writer_top_tb;
    import wfsw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned PHASES = 8;
    localparam int unsigned PHASE_REQS = 110;
    localparam int unsigned DRAIN_CYCLES = 16;

    localparam int unsigned PHASE_W [PHASES] = '{320, 511, 1, 0, 37, 8, 0, 320};
    localparam int unsigned PHASE_H [PHASES] = '{240, 255, 1, 17, 0, 8, 0, 240};
    localparam pix_mode_t PHASE_M [PHASES] =
        '{MODE_24, MODE_8, MODE_12, MODE_16, MODE_24, MODE_8, MODE_16, MODE_12};

    typedef struct {
        op_t                       op;
        logic [COORD_W-1:0]        win_col_lo;
        logic [COORD_W-1:0]        win_col_hi;
        logic [COORD_W-1:0]        win_row_lo;
        logic [COORD_W-1:0]        win_row_hi;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [COLOR_W-1:0]        color;
    } pixel_req_t;

    typedef struct {
        logic [COLOR_W-1:0] value;
        logic               hit;
    } pixel_read_t;

    class pixel_scoreboard;
        bit [COLOR_W-1:0] frame_mem [STORE_DEPTH];
        logic [COORD_W-1:0] cur_col;
        logic [COORD_W-1:0] cur_row;
        logic [COORD_W-1:0] win_cl;
        logic [COORD_W-1:0] win_ch;
        logic [COORD_W-1:0] win_rl;
        logic [COORD_W-1:0] win_rh;
        int unsigned width_reg;
        int unsigned height_reg;
        pix_mode_t mode_reg;
        pixel_read_t expected_reads [$];
        int unsigned mismatches;
        int unsigned reads_checked;
        int unsigned pixels_stored;

        function new();
            width_reg = 320;
            height_reg = 240;
            mode_reg = MODE_16;
            cur_col = '0;
            cur_row = '0;
            win_cl = '0;
            win_ch = 16'd319;
            win_rl = '0;
            win_rh = 16'd239;
            mismatches = 0;
            reads_checked = 0;
            pixels_stored = 0;
        endfunction

        function int eff_w();
            return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        endfunction

        function int eff_h();
            return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        endfunction

        function logic [COLOR_W-1:0] color_mask();
            case (mode_reg)
                MODE_8:  return 24'h0000FF;
                MODE_12: return 24'h000FFF;
                MODE_16: return 24'h00FFFF;
                default: return 24'hFFFFFF;
            endcase
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_FRAME_WIDTH:  width_reg = value[FW_W-1:0];
                REG_FRAME_HEIGHT: height_reg = value[FH_W-1:0];
                REG_PIXEL_MODE:   mode_reg = pix_mode_t'(value[1:0]);
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(reg_idx_t idx);
            case (idx)
                REG_FRAME_WIDTH:  return width_reg;
                REG_FRAME_HEIGHT: return height_reg;
                REG_PIXEL_MODE:   return 32'(mode_reg);
                default:          return '0;
            endcase
        endfunction

        function void store_pixel(int col, int row, logic [COLOR_W-1:0] color);
            if (col < eff_w() && row < eff_h())
            begin
                frame_mem[row * eff_w() + col] = color & color_mask();
                pixels_stored++;
            end
        endfunction

        function void note_request(pixel_req_t r);
            int x;
            int y;
            bit in_frame;
            pixel_read_t rd;
            x = r.pos_x;
            y = r.pos_y;
            in_frame = (x >= 0) && (y >= 0) && (x < eff_w()) && (y < eff_h());
            case (r.op)
                OP_SET_WINDOW:
                begin
                    win_cl = r.win_col_lo;
                    win_ch = r.win_col_hi;
                    win_rl = r.win_row_lo;
                    win_rh = r.win_row_hi;
                    cur_col = r.win_col_lo;
                    cur_row = r.win_row_lo;
                end
                OP_STREAM:
                begin
                    if (cur_col > win_ch)
                    begin
                        cur_col = win_cl;
                        cur_row = cur_row + 16'd1;
                    end
                    if (cur_row > win_rh)
                        cur_row = win_rl;
                    store_pixel(int'(cur_col), int'(cur_row), r.color);
                    cur_col = cur_col + 16'd1;
                end
                OP_DRAW:
                begin
                    if (in_frame)
                        store_pixel(x, y, r.color);
                end
                default:
                begin
                    rd.hit = in_frame;
                    rd.value = in_frame ? frame_mem[y * eff_w() + x] : '0;
                    expected_reads.push_back(rd);
                end
            endcase
        endfunction

        task report(string msg);
            if (mismatches < 40)
                $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_response(logic [COLOR_W-1:0] value, logic hit);
            pixel_read_t rd;
            if (expected_reads.size() == 0)
            begin
                report($sformatf("read response %06h hit %0b with no read outstanding",
                                 value, hit));
            end
            else
            begin
                rd = expected_reads.pop_front();
                reads_checked++;
                if (hit !== rd.hit)
                    report($sformatf("hit %0b, expected %0b", hit, rd.hit));
                if (value !== rd.value)
                    report($sformatf("pixel_value %06h, expected %06h", value, rd.value));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    wfsw_in_if in_ch ();
    wfsw_out_if out_ch ();

    pixel_scoreboard sb = new();

    int unsigned cycles = 0;
    int unsigned req_count = 0;
    int unsigned settings_used = 0;
    int unsigned burst_left = 0;
    int unsigned stall_left = 0;
    int unsigned stall_style = 0;

    windowed_frame_store_writer_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reads outstanding", cycles,
                     sb.expected_reads.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_response(out_ch.pixel_value, out_ch.hit);
    end

    // response back-pressure: always ready, light stalls or heavy stalls
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 2);
            stall_left = $urandom_range(50, 300);
        end
        stall_left--;
        case (stall_style)
            0:       out_ch.ready = 1'b1;
            1:       out_ch.ready = ($urandom_range(0, 3) != 0);
            default: out_ch.ready = ($urandom_range(0, 5) == 0);
        endcase
    end

    function automatic pixel_req_t mk_base(op_t op);
        pixel_req_t r;
        r.op = op;
        r.win_col_lo = COORD_W'($urandom);
        r.win_col_hi = COORD_W'($urandom);
        r.win_row_lo = COORD_W'($urandom);
        r.win_row_hi = COORD_W'($urandom);
        r.pos_x = COORD_W'($urandom);
        r.pos_y = COORD_W'($urandom);
        r.color = COLOR_W'($urandom);
        return r;
    endfunction

    function automatic pixel_req_t mk_window(int cl, int ch, int rl, int rh);
        pixel_req_t r;
        r = mk_base(OP_SET_WINDOW);
        r.win_col_lo = COORD_W'(cl);
        r.win_col_hi = COORD_W'(ch);
        r.win_row_lo = COORD_W'(rl);
        r.win_row_hi = COORD_W'(rh);
        return r;
    endfunction

    function automatic pixel_req_t mk_stream(logic [31:0] color);
        pixel_req_t r;
        r = mk_base(OP_STREAM);
        r.color = COLOR_W'(color);
        return r;
    endfunction

    function automatic pixel_req_t mk_draw(int x, int y, logic [31:0] color);
        pixel_req_t r;
        r = mk_base(OP_DRAW);
        r.pos_x = COORD_W'(x);
        r.pos_y = COORD_W'(y);
        r.color = COLOR_W'(color);
        return r;
    endfunction

    function automatic pixel_req_t mk_read(int x, int y);
        pixel_req_t r;
        r = mk_base(OP_READ);
        r.pos_x = COORD_W'(x);
        r.pos_y = COORD_W'(y);
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_req(pixel_req_t r);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_ch.op = r.op;
        in_ch.win_col_lo = r.win_col_lo;
        in_ch.win_col_hi = r.win_col_hi;
        in_ch.win_row_lo = r.win_row_lo;
        in_ch.win_row_hi = r.win_row_hi;
        in_ch.pos_x = r.pos_x;
        in_ch.pos_y = r.pos_y;
        in_ch.color = r.color;
        in_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(r);
        req_count++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid = 1'b0;
        burst_left = 0;
        while (sb.expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_reg(reg_idx_t idx, logic [31:0] value);
        logic [PDATA_W-1:0] readback;
        paddr = {idx, 2'b00};
        pwdata = value;
        pwrite = 1'b1;
        psel = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, value);
        @(negedge clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (readback !== sb.reg_value(idx))
            sb.report($sformatf("register %s reads %0h, expected %0h", idx.name(),
                                readback, sb.reg_value(idx)));
    endtask

    task automatic directed_part();
        send_req(mk_read(0, 0));
        send_req(mk_draw(319, 239, 24'hFFFFFF));
        send_req(mk_read(319, 239));
        send_req(mk_draw(-1, 0, 24'h123456));
        send_req(mk_read(-1, 0));
        send_req(mk_read(320, 0));
        send_req(mk_read(0, 240));
        send_req(mk_read(-32768, 32767));
        // column overflow: cursor runs from the top of the range back to zero
        send_req(mk_window(16'hFFFE, 16'hFFFF, 2, 3));
        send_req(mk_stream(24'hABCDEF));
        send_req(mk_stream(24'h00FF00));
        send_req(mk_stream(24'hFFFFFF));
        send_req(mk_stream(24'h000000));
        send_req(mk_read(0, 2));
        send_req(mk_read(1, 2));
        // row overflow: the step down wraps from the last row to zero
        send_req(mk_window(5, 6, 16'hFFFF, 16'hFFFF));
        send_req(mk_stream(24'h111111));
        send_req(mk_stream(24'h222222));
        send_req(mk_stream(24'h333333));
        send_req(mk_read(5, 0));
        // window wrap back to the top-left corner
        send_req(mk_window(10, 11, 20, 20));
        send_req(mk_stream(24'h0A0A0A));
        send_req(mk_stream(24'h0B0B0B));
        send_req(mk_stream(24'h0C0C0C));
        send_req(mk_read(10, 20));
    endtask

    task automatic random_phase(int unsigned n_req);
        int unsigned target;
        int unsigned kind;
        int w;
        int h;
        int cl;
        int rl;
        int cw;
        int rh;
        int x;
        int y;
        target = req_count + n_req;
        while (req_count < target)
        begin
            w = sb.eff_w();
            h = sb.eff_h();
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                cl = $urandom_range(0, w + 2);
                rl = $urandom_range(0, h + 2);
                cw = $urandom_range(0, 7);
                rh = $urandom_range(0, 3);
                if ($urandom_range(0, 9) == 0)
                    send_req(mk_window(cl + cw, cl, rl + rh, rl));
                else
                    send_req(mk_window(cl, cl + cw, rl, rl + rh));
                repeat ($urandom_range(1, 24))
                    send_req(mk_stream($urandom));
                repeat ($urandom_range(1, 4))
                    send_req(mk_read(cl + $urandom_range(0, cw + 1),
                                     rl + $urandom_range(0, rh + 1)));
            end
            else if (kind < 65)
            begin
                x = int'($urandom_range(0, w + 1)) - 1;
                y = int'($urandom_range(0, h + 1)) - 1;
                send_req(mk_draw(x, y, $urandom));
                if ($urandom_range(0, 2) != 0)
                    send_req(mk_read(x, y));
            end
            else if (kind < 80)
            begin
                x = int'($urandom_range(0, w + 1)) - 1;
                y = int'($urandom_range(0, h + 1)) - 1;
                send_req(mk_read(x, y));
            end
            else
            begin
                send_req(mk_base(op_t'($urandom_range(0, 3))));
            end
        end
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        pix_mode_t m;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_SET_WINDOW;
        in_ch.win_col_lo = '0;
        in_ch.win_col_hi = '0;
        in_ch.win_row_lo = '0;
        in_ch.win_row_hi = '0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.color = '0;
        out_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_part();
        settings_used = 1;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            w = PHASE_W[p];
            h = PHASE_H[p];
            m = PHASE_M[p];
            if (p == 6)
            begin
                w = $urandom_range(1, 511);
                h = $urandom_range(1, 255);
                m = pix_mode_t'($urandom_range(0, 3));
            end
            set_reg(REG_FRAME_WIDTH, w);
            set_reg(REG_FRAME_HEIGHT, h);
            set_reg(REG_PIXEL_MODE, 32'(m));
            settings_used++;
            random_phase(PHASE_REQS);
        end
        wait_idle();

        $display("%0d requests sent over %0d frame settings in %0d cycles", req_count,
                 settings_used, cycles);
        $display("%0d reads checked, %0d pixels stored, %0d mismatches", sb.reads_checked,
                 sb.pixels_stored, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
